FILE: rtl/cobsfd_pkg.sv
// Shared types and constants for the COBS frame decoder.
// No dependencies; used by cobs_frame_decoder.
package cobsfd_pkg;

  localparam int BYTE_W = 8;

  // Bit positions of the flags carried in the result tuser.
  localparam int USER_HAS_DATA    = 0;
  localparam int USER_FRAME_ERROR = 1;
  localparam int USER_W           = 2;

  // One decoded result as held in the output register.
  typedef struct packed {
    logic              frame_error;
    logic              frame_end;
    logic              has_data;
    logic [BYTE_W-1:0] out_byte;
  } result_t;

endpackage

FILE: rtl/cobs_frame_decoder.sv
// COBS frame decoder: splits a byte stream at zero bytes and undoes the
// consistent overhead byte stuffing. Depends on cobsfd_pkg.
//
// Channel  Dir  Handshake                 Payload
// s_*      in   s_tvalid / s_tready       s_tdata = rx_byte
// m_*      out  m_tvalid / m_tready       m_tdata = out_byte, m_tlast = frame_end,
//                                         m_tuser = {frame_error, has_data}
//
// One byte is taken per cycle while the output is not stalled. A byte is
// captured in an input register; when the decode step runs, the decode state
// is updated and any result is written to the output register, from which it
// is offered on m_*. The decode state update is a single countdown/phase step,
// which sets the rate of one byte per clock while the output is not stalled.
// Reset is synchronous and active high; it puts the decoder at frame start.
// When the output register holds a result that is not taken, the decode step
// and then the input register stall; s_tready falls only when both are full.
module cobs_frame_decoder #(
  parameter int DROP_SPAN = 255
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [cobsfd_pkg::BYTE_W-1:0] s_tdata,   // [7:0] rx_byte
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [cobsfd_pkg::BYTE_W-1:0] m_tdata,   // [7:0] out_byte
  output logic                         m_tlast,   // frame_end
  output logic [cobsfd_pkg::USER_W-1:0] m_tuser    // [0] has_data, [1] frame_error
);

  // Phase counter counts modulo DROP_SPAN.
  localparam int PW = (DROP_SPAN > 2) ? $clog2(DROP_SPAN) : 1;
  localparam logic [PW-1:0] PHASE_LAST = PW'(DROP_SPAN - 1);

  localparam int BW = cobsfd_pkg::BYTE_W;

  // Input register.
  logic          in_valid;
  logic [BW-1:0] in_byte;

  // Decode state.
  logic          at_frame_start, at_frame_start_next;
  logic [BW-1:0] code_countdown, code_countdown_next;
  logic [PW-1:0] position_phase, position_phase_next;
  logic [BW-1:0] held_byte, held_byte_next;
  logic          held_valid, held_valid_next;
  logic          chain_broken, chain_broken_next;

  // Output register.
  logic                result_valid, result_valid_next;
  cobsfd_pkg::result_t result, result_next;

  logic          advance;
  logic [BW-1:0] dec_byte;

  // The decode step runs when the output register is free or being emptied.
  assign advance  = !result_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_comb begin
    at_frame_start_next = at_frame_start;
    code_countdown_next = code_countdown;
    position_phase_next = position_phase;
    held_byte_next      = held_byte;
    held_valid_next     = held_valid;
    chain_broken_next   = chain_broken;
    result_valid_next   = 1'b0;
    result_next         = '0;
    dec_byte            = in_byte;

    if (in_byte == '0) begin
      // Delimiter: flush the held byte (if any) with the end mark. The chain
      // must land exactly here unless the frame was empty.
      result_valid_next       = 1'b1;
      result_next.has_data    = held_valid;
      result_next.out_byte    = held_valid ? held_byte : '0;
      result_next.frame_end   = 1'b1;
      result_next.frame_error = !at_frame_start &&
                                ((code_countdown != BW'(1)) || chain_broken);
      at_frame_start_next     = 1'b1;
      code_countdown_next     = '0;
      position_phase_next     = '0;
      held_byte_next          = '0;
      held_valid_next         = 1'b0;
      chain_broken_next       = 1'b0;
    end else if (at_frame_start) begin
      // Leading code byte: load the distance to the first code position.
      at_frame_start_next = 1'b0;
      code_countdown_next = in_byte;
      position_phase_next = '0;
    end else begin
      if (code_countdown == BW'(1)) begin
        // Code position decodes to zero and reloads the countdown.
        dec_byte            = '0;
        code_countdown_next = in_byte;
      end else if (code_countdown == '0) begin
        chain_broken_next = 1'b1;
      end else begin
        code_countdown_next = code_countdown - BW'(1);
      end

      // Phase zero marks a stuffed position, which is dropped silently.
      if (position_phase != '0) begin
        if (held_valid) begin
          result_valid_next    = 1'b1;
          result_next.has_data = 1'b1;
          result_next.out_byte = held_byte;
        end
        held_byte_next  = dec_byte;
        held_valid_next = 1'b1;
      end

      position_phase_next = (position_phase == PHASE_LAST) ? '0
                                                           : position_phase + PW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_byte <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_frame_start <= 1'b1;
      code_countdown <= '0;
      position_phase <= '0;
      held_valid     <= 1'b0;
      chain_broken   <= 1'b0;
      result_valid   <= 1'b0;
    end else if (advance) begin
      result_valid <= in_valid && result_valid_next;
      if (in_valid) begin
        at_frame_start <= at_frame_start_next;
        code_countdown <= code_countdown_next;
        position_phase <= position_phase_next;
        held_valid     <= held_valid_next;
        chain_broken   <= chain_broken_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      held_byte <= held_byte_next;
      result    <= result_next;
    end
  end

  assign m_tvalid = result_valid;
  assign m_tdata  = result.out_byte;
  assign m_tlast  = result.frame_end;
  assign m_tuser[cobsfd_pkg::USER_HAS_DATA]    = result.has_data;
  assign m_tuser[cobsfd_pkg::USER_FRAME_ERROR] = result.frame_error;

  // A result without data can only be the end-of-frame transfer.
  a_nodata_is_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[cobsfd_pkg::USER_HAS_DATA] |-> m_tlast)
    else $error("result without data is not marked as frame end");

  // An error flag only rides on the end-of-frame transfer.
  a_error_at_end: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[cobsfd_pkg::USER_FRAME_ERROR] |-> m_tlast)
    else $error("frame error raised before the frame end");

  // Nothing is held while waiting for a leading code byte.
  a_start_empty: assert property (@(posedge clk) disable iff (rst)
    at_frame_start |-> !held_valid && !chain_broken)
    else $error("held state left over at frame start");

  // A processed delimiter returns the decoder to frame start.
  a_delim_restart: assert property (@(posedge clk) disable iff (rst)
    advance && in_valid && (in_byte == '0) |=> at_frame_start)
    else $error("decoder not at frame start after a delimiter");

endmodule

FILE: tb/sv/tb_cobs_frame_decoder.sv
// Self-checking testbench for cobs_frame_decoder: streams COBS frames, noise and
// broken code chains into the decoder and checks each decoded transfer in order.
// Depends on cobsfd_pkg and cobs_frame_decoder.
module tb_cobs_frame_decoder;

  localparam int DROP_SPAN = 255;
  localparam logic [cobsfd_pkg::BYTE_W-1:0] DELIM    = 8'h00;
  localparam logic [cobsfd_pkg::BYTE_W-1:0] MAX_CODE = 8'hFF;
  localparam int MAX_BLOCK = 254;      // data bytes covered by one maximal code
  localparam int STALL_LIMIT = 2000;   // cycles with no transfer on either side
  localparam int HOLD_OFF = 250;       // long receiver stall in the pressure test

  logic                          clk;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [cobsfd_pkg::BYTE_W-1:0] s_tdata;
  logic                          m_tvalid;
  logic                          m_tready;
  logic [cobsfd_pkg::BYTE_W-1:0] m_tdata;
  logic                          m_tlast;
  logic [cobsfd_pkg::USER_W-1:0] m_tuser;

  cobs_frame_decoder #(.DROP_SPAN(DROP_SPAN)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  // Decoder state as the testbench tracks it.
  logic                          dec_at_start;
  logic [cobsfd_pkg::BYTE_W-1:0] dec_countdown;
  logic [cobsfd_pkg::BYTE_W-1:0] dec_phase;
  logic [cobsfd_pkg::BYTE_W-1:0] dec_held;
  logic                          dec_held_valid;
  logic                          dec_broken;

  cobsfd_pkg::result_t           pending_decodes[$];
  logic [cobsfd_pkg::BYTE_W-1:0] frame_bytes[$];
  logic [cobsfd_pkg::BYTE_W-1:0] code_block[$];

  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int recv_hold_cycles = 0;
  int stall_cycles = 0;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic decoder_clear();
    dec_at_start   = 1'b1;
    dec_countdown  = '0;
    dec_phase      = '0;
    dec_held       = '0;
    dec_held_valid = 1'b0;
    dec_broken     = 1'b0;
  endtask

  // Advances the tracked decoder by one received byte and queues the result
  // that byte causes, if any.
  task automatic cobs_decode_step(input logic [cobsfd_pkg::BYTE_W-1:0] rx);
    cobsfd_pkg::result_t           r;
    logic [cobsfd_pkg::BYTE_W-1:0] dec;
    logic                          err;
    r = '0;
    if (rx == DELIM) begin
      // A delimiter at frame start is an empty frame and never an error.
      err = 1'b0;
      if (!dec_at_start) err = (dec_countdown != 8'd1) || dec_broken;
      r.out_byte    = dec_held_valid ? dec_held : '0;
      r.has_data    = dec_held_valid;
      r.frame_end   = 1'b1;
      r.frame_error = err;
      pending_decodes = {pending_decodes, r};
      decoder_clear();
    end else if (dec_at_start) begin
      dec_at_start  = 1'b0;
      dec_countdown = rx;
      dec_phase     = '0;
    end else begin
      if (dec_countdown == 8'd1) begin
        // This byte sits on a code position: it decodes to zero and carries
        // the distance to the next code.
        dec = '0;
        dec_countdown = rx;
      end else if (dec_countdown == 8'd0) begin
        dec = rx;
        dec_broken = 1'b1;
      end else begin
        dec = rx;
        dec_countdown = dec_countdown - 8'd1;
      end
      // Phase zero marks a stuffed position, which is dropped silently.
      if (dec_phase != 8'd0) begin
        if (dec_held_valid) begin
          r.out_byte = dec_held;
          r.has_data = 1'b1;
          pending_decodes = {pending_decodes, r};
        end
        dec_held       = dec;
        dec_held_valid = 1'b1;
      end
      if (int'(dec_phase) + 1 >= DROP_SPAN) dec_phase = '0;
      else dec_phase = dec_phase + 8'd1;
    end
  endtask

  // Offers one byte on the input stream and returns once it is transferred.
  task automatic send_rx_byte(input logic [cobsfd_pkg::BYTE_W-1:0] b);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    cobs_decode_step(b);
  endtask

  task automatic send_frame_bytes();
    foreach (frame_bytes[i]) send_rx_byte(frame_bytes[i]);
  endtask

  // Encodes a random message of len bytes into frame_bytes, delimiter included.
  task automatic build_cobs_frame(input int len, input int zero_pct);
    logic [cobsfd_pkg::BYTE_W-1:0] b;
    frame_bytes.delete();
    code_block.delete();
    for (int i = 0; i < len; i++) begin
      b = ($urandom_range(0, 99) < zero_pct) ? DELIM
                                             : cobsfd_pkg::BYTE_W'($urandom_range(1, 255));
      if (b == DELIM) begin
        frame_bytes = {frame_bytes, cobsfd_pkg::BYTE_W'(code_block.size() + 1)};
        foreach (code_block[j]) frame_bytes = {frame_bytes, code_block[j]};
        code_block.delete();
      end else begin
        code_block = {code_block, b};
        if (code_block.size() == MAX_BLOCK) begin
          frame_bytes = {frame_bytes, MAX_CODE};
          foreach (code_block[j]) frame_bytes = {frame_bytes, code_block[j]};
          code_block.delete();
        end
      end
    end
    frame_bytes = {frame_bytes, cobsfd_pkg::BYTE_W'(code_block.size() + 1)};
    foreach (code_block[j]) frame_bytes = {frame_bytes, code_block[j]};
    frame_bytes = {frame_bytes, DELIM};
  endtask

  // Breaks the code chain of the frame in frame_bytes: overwrite a byte,
  // lose the last byte before the delimiter, or add one there.
  task automatic corrupt_frame();
    int idx;
    idx = $urandom_range(0, frame_bytes.size() - 2);
    case ($urandom_range(0, 2))
      0: frame_bytes[idx] = cobsfd_pkg::BYTE_W'($urandom_range(1, 255));
      1: if (frame_bytes.size() > 2) frame_bytes.delete(frame_bytes.size() - 2);
      default: frame_bytes.insert(frame_bytes.size() - 1,
                                  cobsfd_pkg::BYTE_W'($urandom_range(1, 255)));
    endcase
  endtask

  task automatic build_noise(input int len);
    frame_bytes.delete();
    for (int i = 0; i < len; i++)
      frame_bytes = {frame_bytes,
                     ($urandom_range(0, 7) == 0) ? DELIM
                                                 : cobsfd_pkg::BYTE_W'($urandom_range(0, 255))};
  endtask

  // Short hand-picked frames: empty frame, minimal codes, a chain miss,
  // a code position inside the frame and the byte extremes.
  task automatic test_directed_frames();
    logic [cobsfd_pkg::BYTE_W-1:0] seq [0:25];
    seq = '{8'h00,
            8'h01, 8'h00,
            8'h02, 8'hFF, 8'h00,
            8'h03, 8'h11, 8'h22, 8'h00,
            8'h05, 8'hAA, 8'hBB, 8'h00,
            8'h04, 8'h80, 8'h7F, 8'h01, 8'h00,
            8'hFF, 8'h01, 8'h00,
            8'h02, 8'h33, 8'h01, 8'h00};
    foreach (seq[i]) send_rx_byte(seq[i]);
  endtask

  // Frames long enough to cross a drop position past the first one.
  task automatic test_drop_span();
    build_cobs_frame(258, 0);
    send_frame_bytes();
    build_cobs_frame(300, 10);
    send_frame_bytes();
  endtask

  // Mostly well-formed frames with random content, the rest broken frames
  // and raw noise.
  task automatic test_random_stream(input int budget);
    int sent;
    int pick;
    int len;
    sent = 0;
    while (sent < budget) begin
      pick = $urandom_range(0, 99);
      len  = $urandom_range(0, 99);
      len  = (len < 75) ? $urandom_range(0, 12)
           : (len < 97) ? $urandom_range(13, 60) : $urandom_range(200, 300);
      if (pick < 85) begin
        build_cobs_frame(len, $urandom_range(0, 40));
        if (pick >= 70) corrupt_frame();
      end else begin
        build_noise($urandom_range(1, 12));
      end
      sent += frame_bytes.size();
      send_frame_bytes();
    end
  endtask

  // The receiver holds off while the sender keeps offering bytes, so the
  // decoder fills up and must stall its input.
  task automatic test_output_stall();
    recv_hold_cycles = HOLD_OFF;
    build_cobs_frame(40, 10);
    send_frame_bytes();
  endtask

  always @(negedge clk) begin
    if (recv_hold_cycles > 0) begin
      m_tready = 1'b0;
      recv_hold_cycles--;
    end else begin
      m_tready = ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Compares every output transfer with the oldest queued result.
  always @(posedge clk) begin
    cobsfd_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_decodes.size() == 0) begin
        $error("unexpected transfer: out_byte %h last %b user %b", m_tdata, m_tlast, m_tuser);
        errors++;
      end else begin
        want = pending_decodes.pop_front();
        if (m_tdata !== want.out_byte) begin
          $error("out_byte: expected %h, got %h", want.out_byte, m_tdata);
          errors++;
        end
        if (m_tuser[cobsfd_pkg::USER_HAS_DATA] !== want.has_data) begin
          $error("has_data: expected %b, got %b", want.has_data,
                 m_tuser[cobsfd_pkg::USER_HAS_DATA]);
          errors++;
        end
        if (m_tlast !== want.frame_end) begin
          $error("frame_end: expected %b, got %b", want.frame_end, m_tlast);
          errors++;
        end
        if (m_tuser[cobsfd_pkg::USER_FRAME_ERROR] !== want.frame_error) begin
          $error("frame_error: expected %b, got %b", want.frame_error,
                 m_tuser[cobsfd_pkg::USER_FRAME_ERROR]);
          errors++;
        end
      end
    end
  end

  // Ends the run if neither side moves a transfer for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;
    decoder_clear();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_idle_pct = 30;
    recv_idle_pct = 63;
    test_directed_frames();
    test_output_stall();
    test_drop_span();
    test_random_stream(220);

    send_idle_pct = 63;
    recv_idle_pct = 30;
    test_random_stream(220);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_stream(220);

    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_decodes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
